### src/kceg_pkg.sv
// Shared types, constants and the key-location table of the keypad change-event generator.
// Used by every module of the block; depends on nothing.
`default_nettype none
package kceg_pkg;

  localparam int BOARDS         = 6;
  localparam int KEYS_PER_BOARD = 16;
  localparam int BOARD_W        = 3;
  localparam int KEY_W          = 4;
  localparam int RAW_W          = 48;
  localparam int SCAN_W         = 10;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);

  localparam logic [SCAN_W-1:0] SCAN_LIMIT     = 10'd1000;
  localparam logic [SCAN_W-1:0] HOLDOFF_RESET  = 10'd100;
  localparam logic [3:0]        BIT_SEL_MAX    = 4'd7;

  // Each entry: byte number in the high nibble, bit number in the low nibble.
  localparam logic [7:0] KEY_MAP [KEYS_PER_BOARD] = '{
    8'h07, 8'h04, 8'h02, 8'h22,
    8'h05, 8'h06, 8'h00, 8'h01,
    8'h03, 8'h10, 8'h30, 8'h21,
    8'h13, 8'h12, 8'h11, 8'h31
  };

  typedef struct packed {
    logic [BOARD_W-1:0] board;
    logic [RAW_W-1:0]   raw_key_bytes;
  } item_t;

  typedef struct packed {
    logic [BOARD_W+KEY_W-1:0] key_index;
    logic                     pressed;
    logic                     last;
  } result_t;

  // One board's worth of work handed from the front to the back.
  typedef struct packed {
    logic [BOARD_W-1:0]        board;
    logic [KEYS_PER_BOARD-1:0] changed;
    logic [KEYS_PER_BOARD-1:0] states;
  } change_t;

endpackage
`default_nettype wire

### src/kceg_front.sv
// Front end: accepts board scans, decodes key states, tracks prior states and the scan counter.
// Depends on kceg_pkg.
`default_nettype none
module kceg_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire logic                         full,
  input  wire kceg_pkg::item_t              item,
  input  wire logic                         cfg_valid,
  input  wire logic [kceg_pkg::SCAN_W-1:0]  cfg_data,
  output logic                              q_push,
  output kceg_pkg::change_t                 q_data
);

  logic [kceg_pkg::KEYS_PER_BOARD-1:0] prior [kceg_pkg::BOARDS];
  logic [kceg_pkg::SCAN_W-1:0]         scan_count;
  logic [kceg_pkg::SCAN_W-1:0]         holdoff_scans;
  logic [kceg_pkg::KEYS_PER_BOARD-1:0] now;
  logic [kceg_pkg::KEYS_PER_BOARD-1:0] old;
  logic                                accept;
  logic                                board_ok;
  logic                                emit;

  always_comb begin
    logic [7:0] loc;
    logic [7:0] byte_val;
    for (int k = 0; k < kceg_pkg::KEYS_PER_BOARD; k++) begin
      loc      = kceg_pkg::KEY_MAP[k];
      byte_val = item.raw_key_bytes[8*loc[6:4] +: 8];
      now[k]   = (loc[3:0] > kceg_pkg::BIT_SEL_MAX) ? 1'b0 : byte_val[loc[2:0]];
    end
  end

  assign accept   = push && !full;
  assign board_ok = item.board < kceg_pkg::BOARD_W'(kceg_pkg::BOARDS);
  assign old      = board_ok ? prior[item.board] : '0;
  assign emit     = scan_count > holdoff_scans;

  assign q_data.board   = item.board;
  assign q_data.changed = now ^ old;
  assign q_data.states  = now;
  assign q_push         = accept && board_ok && emit && (|(now ^ old));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < kceg_pkg::BOARDS; b++) begin
        prior[b] <= '0;
      end
      scan_count    <= '0;
      holdoff_scans <= kceg_pkg::HOLDOFF_RESET;
    end else begin
      if (cfg_valid) begin
        holdoff_scans <= cfg_data;
      end
      if (accept && board_ok) begin
        prior[item.board] <= now;
        if (item.board == kceg_pkg::BOARD_W'(kceg_pkg::BOARDS - 1) &&
            scan_count < kceg_pkg::SCAN_LIMIT) begin
          scan_count <= scan_count + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### src/kceg_queue.sv
// Short queue of per-board change sets between the front and the back.
// Depends on kceg_pkg.
`default_nettype none
module kceg_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr,
  input  wire kceg_pkg::change_t wr_data,
  input  wire logic              rd,
  output kceg_pkg::change_t      rd_data,
  output logic                   full,
  output logic                   empty
);

  kceg_pkg::change_t                mem [kceg_pkg::QUEUE_DEPTH];
  logic [kceg_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [kceg_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [kceg_pkg::QUEUE_PTR_W:0]   count;
  logic                             do_wr;
  logic                             do_rd;

  assign full    = count == (kceg_pkg::QUEUE_PTR_W+1)'(kceg_pkg::QUEUE_DEPTH);
  assign empty   = count == '0;
  assign rd_data = mem[rd_ptr];
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### src/kceg_back.sv
// Back end: walks one change set in ascending key order and emits one event per changed key.
// Depends on kceg_pkg.
`default_nettype none
module kceg_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire kceg_pkg::change_t q_data,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output kceg_pkg::result_t      result,
  output logic                   empty,
  input  wire logic              pop
);

  logic                                active;
  logic [kceg_pkg::BOARD_W-1:0]        board;
  logic [kceg_pkg::KEYS_PER_BOARD-1:0] remain;
  logic [kceg_pkg::KEYS_PER_BOARD-1:0] states;
  logic                                out_valid;
  logic                                advance;
  logic                                step;
  logic [kceg_pkg::KEY_W-1:0]          key;
  logic [kceg_pkg::KEYS_PER_BOARD-1:0] remain_next;
  logic                                done;

  // Lowest pending key.
  always_comb begin
    key = '0;
    for (int i = kceg_pkg::KEYS_PER_BOARD - 1; i >= 0; i--) begin
      if (remain[i]) begin
        key = kceg_pkg::KEY_W'(i);
      end
    end
  end

  assign advance     = !out_valid || pop;
  assign step        = active && advance;
  assign remain_next = remain & ~(kceg_pkg::KEYS_PER_BOARD'(1) << key);
  assign done        = remain_next == '0;
  assign q_pop       = !q_empty && (!active || (step && done));
  assign empty       = !out_valid;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      board  <= q_data.board;
      remain <= q_data.changed;
      states <= q_data.states;
    end else if (step) begin
      remain <= remain_next;
    end
    if (step) begin
      result.key_index <= {board, key};
      result.pressed   <= states[key];
      result.last      <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        active <= 1'b1;
      end else if (step && done) begin
        active <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### src/keypad_change_event_generator.sv
// Top level of the keypad change-event generator: front end, change queue and back end.
// Depends on kceg_pkg, kceg_front, kceg_queue and kceg_back.
//
// Each input beat carries the six raw key-matrix bytes of one key board and the board number.
// The front end decodes the board's sixteen key states through a fixed location table,
// compares them with the stored states of that board, stores the new states, and advances the
// scan counter (saturating at 1000) after the last board of a scan. Board numbers of six and
// above are ignored entirely. When the scan counter exceeds holdoff_scans and some key
// changed, the board's change set enters a four-entry queue. The back end turns each change
// set into one result beat per changed key, lowest key first, with last marking the final
// event of the set. The input takes one beat per cycle while the queue has room; the back end
// delivers one event per cycle while results are popped, so a board with n changed keys
// yields n events (at most sixteen), and the sustained rate is set by that event
// walk. holdoff_scans resets to 100 and is written through the cfg channel, which is always
// ready; it should only be written while the block is idle.
`default_nettype none
module keypad_change_event_generator (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire kceg_pkg::item_t              item,
  output logic                              empty,
  input  wire logic                         pop,
  output kceg_pkg::result_t                 result,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [kceg_pkg::SCAN_W-1:0]  cfg_data
);

  logic              q_push;
  logic              q_pop;
  logic              q_empty;
  kceg_pkg::change_t q_wr_data;
  kceg_pkg::change_t q_rd_data;

  assign cfg_ready = 1'b1;

  // The front end classifies and updates state; it stalls only when the queue is full.
  kceg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  kceg_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wr_data),
    .rd      (q_pop),
    .rd_data (q_rd_data),
    .full    (full),
    .empty   (q_empty)
  );

  // The back end holds a registered result beat; it stalls its walk while a result waits unpopped.
  kceg_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_rd_data),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the keypad change-event generator (top module tb).
// Depends on kceg_pkg for the beat types and on the keypad_change_event_generator RTL.
`timescale 1ns / 1ps
module tb;

  // Key location table: byte number in the high nibble, bit number in the low nibble.
  // Key 0 sits in the lowest byte of the vector.
  localparam logic [kceg_pkg::KEYS_PER_BOARD*8-1:0] KEY_LOC = {
    8'h31, 8'h11, 8'h12, 8'h13,
    8'h21, 8'h30, 8'h10, 8'h03,
    8'h01, 8'h00, 8'h06, 8'h05,
    8'h22, 8'h02, 8'h04, 8'h07
  };
  localparam logic [kceg_pkg::SCAN_W-1:0] HOLDOFF_AT_RESET = 10'd100;
  localparam int SETTLE_CYCLES = 32;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int NUM_ROWS      = 23;

  typedef enum logic {ROW_ITEM, ROW_HOLDOFF} row_kind_t;

  // One directed step. A holdoff row carries the register value in raw.
  // Where typed is set, the row expects n_ev events on consecutive keys of
  // the board, starting at key 0, all with the given pressed value.
  typedef struct packed {
    row_kind_t                    kind;
    logic [kceg_pkg::BOARD_W-1:0] board;
    logic [kceg_pkg::RAW_W-1:0]   raw;
    logic                         typed;
    logic [4:0]                   n_ev;
    logic                         pressed;
  } stim_row_t;

  // The first rows run at the reset holdoff of 100, so every change is stored
  // silently. Holdoff 2 then checks the boundary: events start only once the
  // completed scan count is strictly above it.
  stim_row_t plan [NUM_ROWS] = '{
    '{ROW_ITEM,    3'd0, 48'hFFFF_FFFF_FFFF, 1'b1, 5'd0,  1'b0},
    '{ROW_ITEM,    3'd5, 48'hFFFF_FFFF_FFFF, 1'b1, 5'd0,  1'b0},
    '{ROW_ITEM,    3'd6, 48'hFFFF_FFFF_FFFF, 1'b1, 5'd0,  1'b0},
    '{ROW_ITEM,    3'd7, 48'hFFFF_FFFF_FFFF, 1'b1, 5'd0,  1'b0},
    '{ROW_ITEM,    3'd5, 48'h0000_0000_0000, 1'b1, 5'd0,  1'b0},
    '{ROW_HOLDOFF, 3'd0, 48'd2,              1'b0, 5'd0,  1'b0},
    '{ROW_ITEM,    3'd1, 48'hFFFF_FFFF_FFFF, 1'b1, 5'd0,  1'b0},
    '{ROW_ITEM,    3'd5, 48'hFFFF_FFFF_FFFF, 1'b1, 5'd0,  1'b0},
    '{ROW_ITEM,    3'd0, 48'h0000_0000_0000, 1'b1, 5'd16, 1'b0},
    '{ROW_ITEM,    3'd0, 48'hFFFF_FFFF_FFFF, 1'b1, 5'd16, 1'b1},
    '{ROW_ITEM,    3'd0, 48'hFFFF_FFFF_FFFF, 1'b1, 5'd0,  1'b0},
    '{ROW_ITEM,    3'd1, 48'h0000_0000_0000, 1'b1, 5'd16, 1'b0},
    '{ROW_ITEM,    3'd5, 48'h0000_0000_0000, 1'b1, 5'd16, 1'b0},
    '{ROW_ITEM,    3'd6, 48'h0000_0000_0000, 1'b1, 5'd0,  1'b0},
    '{ROW_ITEM,    3'd3, 48'hFFFF_FCF9_F000, 1'b1, 5'd0,  1'b0},
    '{ROW_HOLDOFF, 3'd0, 48'd0,              1'b0, 5'd0,  1'b0},
    '{ROW_ITEM,    3'd2, 48'h0000_0000_0080, 1'b0, 5'd0,  1'b0},
    '{ROW_ITEM,    3'd2, 48'h0000_0102_0001, 1'b0, 5'd0,  1'b0},
    '{ROW_ITEM,    3'd4, 48'h0000_0306_0A55, 1'b0, 5'd0,  1'b0},
    '{ROW_ITEM,    3'd4, 48'h0000_0000_0000, 1'b0, 5'd0,  1'b0},
    '{ROW_ITEM,    3'd7, 48'hAAAA_AAAA_AAAA, 1'b1, 5'd0,  1'b0},
    '{ROW_ITEM,    3'd5, 48'h5555_5555_5555, 1'b0, 5'd0,  1'b0},
    '{ROW_ITEM,    3'd2, 48'h0000_0000_0000, 1'b0, 5'd0,  1'b0}
  };

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        push      = 1'b0;
  logic                        full;
  kceg_pkg::item_t             item      = '0;
  logic                        empty;
  logic                        pop       = 1'b0;
  kceg_pkg::result_t           result;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [kceg_pkg::SCAN_W-1:0] cfg_data  = '0;

  // Predictor state: the last known level of every key, the completed scan
  // count and the holdoff the block should be using.
  logic [kceg_pkg::BOARDS*kceg_pkg::KEYS_PER_BOARD-1:0] key_states = '0;
  int                                                   scans_done = 0;
  logic [kceg_pkg::SCAN_W-1:0]                          holdoff    = HOLDOFF_AT_RESET;
  kceg_pkg::result_t                                    expected_events [$];

  logic [kceg_pkg::RAW_W-1:0] last_raw [8];
  int               next_board  = 0;
  int               burst_left  = 0;
  int               n_fail      = 0;
  int               events_seen = 0;
  int               rx_cycle    = 0;
  int               hold_left   = 0;
  bit               long_hold_done = 1'b0;
  int               cycles      = 0;

  keypad_change_event_generator u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Level of one key as seen in a board's raw bytes.
  function automatic logic key_level(input logic [kceg_pkg::RAW_W-1:0] raw, input int k);
    logic [7:0] loc;
    logic [7:0] byte_val;
    loc = KEY_LOC[8*k +: 8];
    byte_val = (loc[6:4] < 3'd6) ? raw[8*loc[6:4] +: 8] : 8'h00;
    if (loc[3:0] > 4'd7) return 1'b0;
    return byte_val[loc[2:0]];
  endfunction

  // Updates the stored key levels and scan count for one accepted beat and,
  // when record is set, queues the events the block must produce for it.
  // Events are held back by one so that the final one can carry last.
  task automatic scan_board(input kceg_pkg::item_t it, input bit record);
    logic              emit;
    logic              level;
    bit                have_pend;
    kceg_pkg::result_t pend;
    int                slot;
    emit = scans_done > holdoff;
    have_pend = 1'b0;
    pend = '0;
    if (it.board >= kceg_pkg::BOARDS) return;
    for (int k = 0; k < kceg_pkg::KEYS_PER_BOARD; k++) begin
      slot = it.board * kceg_pkg::KEYS_PER_BOARD + k;
      level = key_level(it.raw_key_bytes, k);
      if (level != key_states[slot]) begin
        if (emit && record) begin
          if (have_pend) expected_events.push_back(pend);
          pend.key_index = 7'(slot);
          pend.pressed = level;
          pend.last = 1'b0;
          have_pend = 1'b1;
        end
        key_states[slot] = level;
      end
    end
    if (have_pend) begin
      pend.last = 1'b1;
      expected_events.push_back(pend);
    end
    if (it.board == kceg_pkg::BOARDS - 1 && scans_done < kceg_pkg::SCAN_LIMIT) scans_done++;
  endtask

  // New raw bytes for a board: mostly a few flipped bits against the last
  // bytes seen, now and then fully random or fully inverted.
  function automatic logic [kceg_pkg::RAW_W-1:0] mutate(input logic [kceg_pkg::RAW_W-1:0] raw);
    int unsigned                pick;
    logic [kceg_pkg::RAW_W-1:0] flips;
    pick = $urandom_range(0, 9);
    flips = kceg_pkg::RAW_W'({$urandom, $urandom}) & kceg_pkg::RAW_W'({$urandom, $urandom}) &
            kceg_pkg::RAW_W'({$urandom, $urandom});
    if (pick == 0) return kceg_pkg::RAW_W'({$urandom, $urandom});
    if (pick == 1) return ~raw;
    return raw ^ flips;
  endfunction

  // Offers one beat and waits until the block takes it. The sender works in
  // bursts; push stays high across a burst and drops only for a gap.
  task automatic offer(input kceg_pkg::item_t it, input bit record);
    int gap;
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    scan_board(it, record);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops offering and waits until every queued event has come out.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
  endtask

  // Holdoff is only written with the block idle. A beat that produced no
  // event may still be in flight after the last event, hence the settle time.
  task automatic set_holdoff(input logic [kceg_pkg::SCAN_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    holdoff = value;
  endtask

  // Random beats, counting only those for real boards. Most follow the
  // regular scan order; some use a stray board number or break the order.
  task automatic random_items(input int count);
    kceg_pkg::item_t it;
    int              done;
    int unsigned     pick;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        it.board = 3'($urandom_range(kceg_pkg::BOARDS, 7));
      end else if (pick == 1) begin
        it.board = 3'($urandom_range(0, kceg_pkg::BOARDS - 1));
      end else begin
        it.board = 3'(next_board);
        next_board = (next_board + 1) % kceg_pkg::BOARDS;
      end
      it.raw_key_bytes = mutate(last_raw[it.board]);
      last_raw[it.board] = it.raw_key_bytes;
      offer(it, 1'b1);
      if (it.board < kceg_pkg::BOARDS) done++;
    end
  endtask

  task automatic check_event(input kceg_pkg::result_t got);
    kceg_pkg::result_t want;
    events_seen++;
    if (expected_events.size() == 0) begin
      n_fail++;
      if (n_fail <= 10)
        $display("unexpected event: key %0d pressed %0b last %0b",
                 got.key_index, got.pressed, got.last);
    end else begin
      want = expected_events.pop_front();
      if (got.key_index !== want.key_index || got.pressed !== want.pressed ||
          got.last !== want.last) begin
        n_fail++;
        if (n_fail <= 10)
          $display("event %0d: want key %0d pressed %0b last %0b, got %0d %0b %0b",
                   events_seen, want.key_index, want.pressed, want.last,
                   got.key_index, got.pressed, got.last);
      end
    end
  endtask

  // Receiver: checks every beat taken and picks the next pop value. Its
  // pattern cycles through always-ready, random, sparse and periodic modes.
  // Once, after enough events, it holds off for a long stretch so the
  // internal queue fills and full pushes back on the sender.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_event(result);
      rx_cycle++;
      if (!long_hold_done && events_seen >= 150) begin
        hold_left = 400;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case ((rx_cycle / 97) % 4)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= (rx_cycle % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    kceg_pkg::item_t   it;
    kceg_pkg::result_t ev;
    for (int b = 0; b < 8; b++) last_raw[b] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part: board extremes, stray boards, holdoff boundary, bits
    // the table never reads, and a handful of single-key patterns.
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (plan[r].kind == ROW_HOLDOFF) begin
        set_holdoff(plan[r].raw[kceg_pkg::SCAN_W-1:0]);
      end else begin
        if (plan[r].typed) begin
          for (int i = 0; i < plan[r].n_ev; i++) begin
            ev.key_index = 7'(plan[r].board * kceg_pkg::KEYS_PER_BOARD + i);
            ev.pressed = plan[r].pressed;
            ev.last = (i == plan[r].n_ev - 1);
            expected_events.push_back(ev);
          end
        end
        it.board = plan[r].board;
        it.raw_key_bytes = plan[r].raw;
        last_raw[it.board] = it.raw_key_bytes;
        offer(it, !plan[r].typed);
      end
    end

    // Random part. The sender pauses for a full drain once, and holdoff is
    // moved a few scans ahead so that events stop and then resume.
    random_items(70);
    drain();
    random_items(30);
    set_holdoff(kceg_pkg::SCAN_W'(scans_done + 2));
    random_items(50);
    set_holdoff('0);
    random_items(60);

    // With holdoff at the ceiling nothing may come out. Holdoff is then set
    // to the current scan count, so events resume only after the next
    // completed scan.
    set_holdoff(kceg_pkg::SCAN_LIMIT);
    random_items(30);
    set_holdoff(kceg_pkg::SCAN_W'(scans_done));
    random_items(50);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_fail == 0 && expected_events.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
